@@ sv/cdq_pkg.sv @@
package cdq_pkg;

  // Operation codes carried in the kind field.
  localparam logic [2:0] KIND_PUSH_TAIL = 3'd0;
  localparam logic [2:0] KIND_PUSH_HEAD = 3'd1;
  localparam logic [2:0] KIND_POP_TAIL  = 3'd2;
  localparam logic [2:0] KIND_POP_HEAD  = 3'd3;
  localparam logic [2:0] KIND_PEEK_TAIL = 3'd4;
  localparam logic [2:0] KIND_PEEK_HEAD = 3'd5;

  // Register index of the capacity register.
  localparam logic CFG_IDX_CAPACITY = 1'b0;

  localparam int          MAX_DEPTH_DEF = 1024;
  localparam logic [10:0] CAP_RESET     = 11'd1024;

endpackage

@@ sv/circular_buffer_deque.sv @@
// Double-ended queue of signed 32-bit words held in one synchronous store of MAX_DEPTH
// entries. Each input beat carries one operation (push or pop or peek, at the back or the
// front) and yields exactly one result beat with an ok flag, the word read (zero unless a
// pop or peek succeeded), the empty flag and the entry count after the operation. The block
// takes one beat per clock cycle while in_stall is low, and its result appears in the
// output register in the cycle after acceptance; that rate is set by the single store
// access each operation needs, a write for a push or a registered read for a pop or peek,
// both issued in the cycle of acceptance. The output register stalls the input while its
// beat is held by the downstream side. The number of entries in use is set by the capacity
// register (byte address 0), read back through the same port. After a write to it the
// pointers are reduced modulo the new capacity by a shift-and-subtract unit; in_stall is
// high during that pass. The store is not cleared at reset, so entries hold whatever they
// held until pushed.
module circular_buffer_deque
  import cdq_pkg::*;
#(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic signed [31:0] in_value,

  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ok,
  output logic signed [31:0] out_value_out,
  output logic               out_empty_res,
  output logic [10:0]        out_count,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Pointer, count and reduction-counter widths all follow from the store depth.
  localparam int PW = $clog2(MAX_DEPTH);
  localparam int CW = $clog2(MAX_DEPTH + 1);
  localparam int NW = $clog2(PW + 1);
  localparam int SW = CW + PW;

  // ------------------------------------------------------------------
  // Configuration port.
  // ------------------------------------------------------------------
  logic [10:0]   cap_r;
  logic [CW-1:0] cap_eff;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_CAPACITY);
  assign prdata = (paddr[2] == CFG_IDX_CAPACITY) ? {21'd0, cap_r} : 32'd0;

  // A capacity of zero behaves as one, and anything above the store depth as the depth.
  always_comb begin
    if (cap_r == 11'd0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_r) > MAX_DEPTH) begin
      cap_eff = CW'(MAX_DEPTH);
    end else begin
      cap_eff = CW'(cap_r);
    end
  end

  // ------------------------------------------------------------------
  // Pointer arithmetic. The front pointer sits one slot before the front entry and the
  // back pointer one slot after the back entry; both wrap at the effective capacity.
  // ------------------------------------------------------------------
  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p, input logic [CW-1:0] c);
    logic [CW-1:0] s;
    s = CW'(p) + CW'(1);
    return (s >= c) ? '0 : PW'(s);
  endfunction

  function automatic logic [PW-1:0] wrap_dec(input logic [PW-1:0] p, input logic [CW-1:0] c);
    return (p == '0) ? PW'(c - CW'(1)) : p - PW'(1);
  endfunction

  logic [PW-1:0] front_r, front_nxt;
  logic [PW-1:0] back_r, back_nxt;
  logic [CW-1:0] entries_r, entries_nxt;
  logic [PW-1:0] inc_front, dec_front, inc_back, dec_back;

  assign inc_front = wrap_inc(front_r, cap_eff);
  assign dec_front = wrap_dec(front_r, cap_eff);
  assign inc_back  = wrap_inc(back_r, cap_eff);
  assign dec_back  = wrap_dec(back_r, cap_eff);

  // ------------------------------------------------------------------
  // Handshake. The input is held off while the pointers are being reduced and while the
  // output register holds a beat that the downstream side has not yet taken.
  // ------------------------------------------------------------------
  logic norm_busy_r;
  logic out_valid_r;
  logic accept;

  assign in_stall = norm_busy_r || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // ------------------------------------------------------------------
  // Operation decode: new pointers and count, and the one store access this beat needs.
  // ------------------------------------------------------------------
  logic          op_ok;
  logic          op_we;
  logic          op_rd;
  logic [PW-1:0] op_addr;
  logic          is_full;
  logic          is_empty;
  logic          is_single;

  assign is_full   = (entries_r >= cap_eff);
  assign is_empty  = (entries_r == '0);
  assign is_single = (entries_r == CW'(1));

  always_comb begin
    front_nxt   = front_r;
    back_nxt    = back_r;
    entries_nxt = entries_r;
    op_ok       = 1'b0;
    op_we       = 1'b0;
    op_rd       = 1'b0;
    op_addr     = back_r;
    case (in_kind)
      KIND_PUSH_TAIL: begin
        if (!is_full) begin
          op_we       = 1'b1;
          op_addr     = back_r;
          back_nxt    = inc_back;
          entries_nxt = entries_r + CW'(1);
          op_ok       = 1'b1;
          if (is_empty) begin
            front_nxt = dec_back;
          end
        end
      end
      KIND_PUSH_HEAD: begin
        if (!is_full) begin
          op_we       = 1'b1;
          op_addr     = front_r;
          front_nxt   = dec_front;
          entries_nxt = entries_r + CW'(1);
          op_ok       = 1'b1;
          if (is_empty) begin
            back_nxt = inc_front;
          end
        end
      end
      KIND_POP_TAIL: begin
        if (!is_empty) begin
          op_rd       = 1'b1;
          op_addr     = dec_back;
          back_nxt    = dec_back;
          entries_nxt = entries_r - CW'(1);
          op_ok       = 1'b1;
          if (is_single) begin
            front_nxt = inc_front;
          end
        end
      end
      KIND_POP_HEAD: begin
        if (!is_empty) begin
          op_rd       = 1'b1;
          op_addr     = inc_front;
          front_nxt   = inc_front;
          entries_nxt = entries_r - CW'(1);
          op_ok       = 1'b1;
          if (is_single) begin
            back_nxt = dec_back;
          end
        end
      end
      KIND_PEEK_TAIL: begin
        if (!is_empty) begin
          op_rd   = 1'b1;
          op_addr = dec_back;
          op_ok   = 1'b1;
        end
      end
      KIND_PEEK_HEAD: begin
        if (!is_empty) begin
          op_rd   = 1'b1;
          op_addr = inc_front;
          op_ok   = 1'b1;
        end
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Store. One beat performs either a write or a read, never both, and each beat's access
  // completes at its own acceptance edge, so a read always sees every earlier write.
  // The read data register only loads on a read, so it holds while the output stalls.
  // ------------------------------------------------------------------
  logic [31:0] store_mem [MAX_DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (accept && op_we) begin
      store_mem[op_addr] <= in_value;
    end
    if (accept && op_rd) begin
      rdata_r <= store_mem[op_addr];
    end
  end

  // ------------------------------------------------------------------
  // Pointer reduction after a capacity write: restoring remainder, one bit per cycle,
  // both pointers side by side. Subtracting capacity times two to the power k, for k from
  // the top pointer bit down to zero, leaves each pointer below the capacity.
  // ------------------------------------------------------------------
  logic [NW-1:0] norm_cnt_r;
  logic [NW-1:0] norm_shift;
  logic [SW-1:0] norm_div;
  logic [PW-1:0] front_red, back_red;

  assign norm_shift = norm_cnt_r - NW'(1);
  assign norm_div   = SW'(cap_eff) << norm_shift;
  assign front_red  = (SW'(front_r) >= norm_div) ? front_r - PW'(norm_div) : front_r;
  assign back_red   = (SW'(back_r) >= norm_div) ? back_r - PW'(norm_div) : back_r;

  // ------------------------------------------------------------------
  // Control registers.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      front_r     <= '0;
      back_r      <= '0;
      entries_r   <= '0;
      norm_busy_r <= 1'b0;
      norm_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        cap_r       <= pwdata[10:0];
        norm_busy_r <= 1'b1;
        norm_cnt_r  <= NW'(PW);
      end else if (norm_busy_r) begin
        front_r    <= front_red;
        back_r     <= back_red;
        norm_cnt_r <= norm_shift;
        if (norm_cnt_r == NW'(1)) begin
          norm_busy_r <= 1'b0;
        end
      end else if (accept) begin
        front_r   <= front_nxt;
        back_r    <= back_nxt;
        entries_r <= entries_nxt;
      end

      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Output register. The word itself comes straight from the store's read register.
  // ------------------------------------------------------------------
  logic          out_ok_r;
  logic          out_rd_r;
  logic          out_empty_r;
  logic [CW-1:0] out_count_r;
  logic [CW+10:0] count_ext;

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ok_r    <= op_ok;
      out_rd_r    <= op_ok && op_rd;
      out_empty_r <= (entries_nxt == '0);
      out_count_r <= entries_nxt;
    end
  end

  assign count_ext     = (CW + 11)'(out_count_r);
  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_value_out = out_rd_r ? signed'(rdata_r) : 32'sd0;
  assign out_empty_res = out_empty_r;
  assign out_count     = count_ext[10:0];

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  a_entries_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    entries_r <= CW'(MAX_DEPTH))
    else $error("entry count above store depth");

  a_ptrs_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !norm_busy_r |-> (CW'(front_r) < cap_eff) && (CW'(back_r) < cap_eff))
    else $error("pointer at or above capacity outside reduction pass");

  a_read_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op_ok && op_rd) |=> (out_valid_r && out_rd_r))
    else $error("successful read did not reach the output register");

  a_rdata_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(rdata_r))
    else $error("read data changed under a stalled result beat");

  a_no_access_in_reduction: assert property (@(posedge clk) disable iff (!rst_n)
    norm_busy_r |-> !(accept && (op_we || op_rd)))
    else $error("store accessed during pointer reduction");

endmodule

@@ test/circular_buffer_deque_check.sv @@
module circular_buffer_deque_check
  import cdq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic signed [31:0] in_value,

  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_ok,
  input  logic signed [31:0] out_value_out,
  input  logic               out_empty_res,
  input  logic [10:0]        out_count,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,

  output int                 fail_count,
  output int                 answers_waiting
);

  typedef struct packed {
    logic        ok;
    logic [31:0] word;
    logic        empty;
    logic [10:0] count;
  } deque_result_t;

  // Shadow of the deque: store, pointers, occupancy and the capacity register.
  logic [31:0]   word_store [MAX_DEPTH_DEF];
  logic [9:0]    front_slot;
  logic [9:0]    back_slot;
  logic [10:0]   entries;
  logic [10:0]   cap_reg;
  deque_result_t deque_answers [$];
  int            mismatch_total = 0;

  assign fail_count = mismatch_total;

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, seen, wanted);
    mismatch_total++;
  endtask

  function automatic int unsigned slot_inc(input int unsigned p, input int unsigned c);
    return (p + 1 >= c) ? 0 : p + 1;
  endfunction

  function automatic int unsigned slot_dec(input int unsigned p, input int unsigned c);
    return (p == 0) ? c - 1 : p - 1;
  endfunction

  // Applies one operation to the shadow deque and returns the beat it should produce.
  task automatic deque_apply(input logic [2:0] op, input logic [31:0] word,
                             output deque_result_t r);
    int unsigned c;
    int unsigned f;
    int unsigned b;
    int unsigned n;
    logic [31:0] got;
    logic        pass;
    c = 32'(cap_reg);
    if (c == 0) c = 1;
    if (c > MAX_DEPTH_DEF) c = MAX_DEPTH_DEF;
    f = 32'(front_slot);
    b = 32'(back_slot);
    n = 32'(entries);
    // A capacity lowered under live pointers folds them back into range first.
    if (f >= c) f = f % c;
    if (b >= c) b = b % c;
    got  = '0;
    pass = 1'b0;
    case (op)
      KIND_PUSH_TAIL: begin
        if (n < c) begin
          word_store[b] = word;
          if (n == 0) f = slot_dec(b, c);
          b = slot_inc(b, c);
          n++;
          pass = 1'b1;
        end
      end
      KIND_PUSH_HEAD: begin
        if (n < c) begin
          word_store[f] = word;
          if (n == 0) b = slot_inc(f, c);
          f = slot_dec(f, c);
          n++;
          pass = 1'b1;
        end
      end
      KIND_POP_TAIL: begin
        if (n != 0) begin
          b   = slot_dec(b, c);
          got = word_store[b];
          if (n == 1) f = slot_inc(f, c);
          n--;
          pass = 1'b1;
        end
      end
      KIND_POP_HEAD: begin
        if (n != 0) begin
          f   = slot_inc(f, c);
          got = word_store[f];
          if (n == 1) b = slot_dec(b, c);
          n--;
          pass = 1'b1;
        end
      end
      KIND_PEEK_TAIL: begin
        if (n != 0) begin
          got  = word_store[slot_dec(b, c)];
          pass = 1'b1;
        end
      end
      KIND_PEEK_HEAD: begin
        if (n != 0) begin
          got  = word_store[slot_inc(f, c)];
          pass = 1'b1;
        end
      end
      default: ;
    endcase
    front_slot = f[9:0];
    back_slot  = b[9:0];
    entries    = n[10:0];
    r.ok    = pass;
    r.word  = pass ? got : 32'd0;
    r.empty = (n == 0);
    r.count = n[10:0];
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    if (!rst_n) begin
      front_slot = '0;
      back_slot  = '0;
      entries    = '0;
      cap_reg    = CAP_RESET;
      deque_answers.delete();
    end else begin
      // Results leave before new work is booked: a beat seen now came from an earlier item.
      if (out_valid && !out_stall) begin
        if (deque_answers.size() == 0) begin
          report_mismatch("result beat with nothing expected", {21'd0, out_count}, '0);
        end else begin
          want = deque_answers[0];
          deque_answers.delete(0);
          if (out_ok !== want.ok) report_mismatch("ok", 32'(out_ok), 32'(want.ok));
          if (out_value_out !== want.word) report_mismatch("value_out", out_value_out, want.word);
          if (out_empty_res !== want.empty) begin
            report_mismatch("empty_res", 32'(out_empty_res), 32'(want.empty));
          end
          if (out_count !== want.count) begin
            report_mismatch("count", 32'(out_count), 32'(want.count));
          end
        end
      end
      if (psel && penable && pready && (paddr >> 2) == 3'(CFG_IDX_CAPACITY)) begin
        if (!pwrite) begin
          if (prdata !== {21'd0, cap_reg}) begin
            report_mismatch("capacity readback", prdata, 32'(cap_reg));
          end
        end else begin
          cap_reg = pwdata[10:0];
        end
      end
      if (in_valid && !in_stall) begin
        deque_apply(in_kind, in_value, want);
        deque_answers = {deque_answers, want};
      end
    end
    answers_waiting <= deque_answers.size();
  end

endmodule

@@ test/circular_buffer_deque_test.sv @@
module circular_buffer_deque_test;
  import cdq_pkg::*;

  // Generous ceiling: several times the slowest run the stimulus can produce.
  localparam int CYCLE_LIMIT = 600000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_kind;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic               out_stall;
  logic               out_ok;
  logic signed [31:0] out_value_out;
  logic               out_empty_res;
  logic [10:0]        out_count;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int          fail_count;
  int          answers_waiting;
  int          cycle_count = 0;
  logic [10:0] last_count = '0;

  // Capacity for each random phase: both ends of the range, the values that fold onto
  // them (zero and anything past the maximum), and a spread of sizes in between.
  int phase_caps [0:10] = '{1, 2, 3, 2047, 5, 16, 1024, 7, 0, 64, 1000};

  circular_buffer_deque u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ok        (out_ok),
    .out_value_out (out_value_out),
    .out_empty_res (out_empty_res),
    .out_count     (out_count),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  circular_buffer_deque_check u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_value_out   (out_value_out),
    .out_empty_res   (out_empty_res),
    .out_count       (out_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .answers_waiting (answers_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The occupancy reported by the most recent result beat tells the stimulus how many
  // pops will empty the deque before the capacity is touched.
  always @(posedge clk) begin
    if (out_valid && !out_stall) last_count <= out_count;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Idle lengths: mostly none, often a few cycles, now and then a long hole.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(50, 20);
  endfunction

  // Words are mostly random, with the signed extremes, zero and all-ones mixed in.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Operation mix for the random part; push_pct steers the deque towards full or empty.
  function automatic logic [2:0] pick_op(input int push_pct);
    int r;
    r = $urandom_range(99);
    if (r < 3) return 3'($urandom_range(7, 6));
    if (r < 15) return $urandom_range(1) ? KIND_PEEK_TAIL : KIND_PEEK_HEAD;
    if (r < 15 + (push_pct * 85) / 100)
      return $urandom_range(1) ? KIND_PUSH_TAIL : KIND_PUSH_HEAD;
    return $urandom_range(1) ? KIND_POP_TAIL : KIND_POP_HEAD;
  endfunction

  // The result side holds stall low for stretches of varying length, sometimes very long
  // ones, and raises it for a mostly short while in between.
  initial begin
    int free_run;
    out_stall <= 1'b0;
    forever begin
      free_run = ($urandom_range(9) == 0) ? $urandom_range(150, 40) : 1 + pick_gap();
      repeat (free_run) @(posedge clk);
      out_stall <= 1'b1;
      repeat (1 + pick_gap()) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // Offers one beat and holds it until the block takes it, then idles for a random gap.
  // When no gap follows, valid simply stays high for the next beat.
  task automatic send_op(input logic [2:0] op, input logic [31:0] word);
    int gap;
    in_valid <= 1'b1;
    in_kind  <= op;
    in_value <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every owed result beat has come back, then allows a
  // few more cycles so that the block has settled before the port is used.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One write through the register port: setup cycle, then access until pready.
  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // A read-back, checked by the checker on the access cycle.
  task automatic cfg_read(input logic [2:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Upper bits of the capacity word are junk that the register must drop.
  task automatic set_capacity(input int cap);
    logic [31:0] data;
    data       = $urandom();
    data[10:0] = cap[10:0];
    cfg_write(3'd0, data);
    cfg_read(3'd0);
  endtask

  initial begin
    int          push_pct;
    logic [10:0] to_pop;

    // Every input is known from time zero.
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_kind  <= KIND_PUSH_TAIL;
    in_value <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening. Every pop and peek on an empty deque is refused, and unknown
    // operation codes leave it untouched.
    send_op(KIND_POP_HEAD, $urandom());
    send_op(KIND_PEEK_TAIL, $urandom());
    send_op(KIND_POP_TAIL, $urandom());
    send_op(KIND_PEEK_HEAD, $urandom());
    send_op(3'd6, $urandom());
    send_op(3'd7, $urandom());

    // Extreme words at both ends. Written from reset at full capacity, these land in
    // slots 0, 1 and the top two slots of the store.
    send_op(KIND_PUSH_TAIL, 32'h7FFF_FFFF);
    send_op(KIND_PUSH_HEAD, 32'h8000_0000);
    send_op(KIND_PUSH_TAIL, 32'h0000_0000);
    send_op(KIND_PUSH_HEAD, 32'hFFFF_FFFF);
    send_op(KIND_PEEK_TAIL, $urandom());
    send_op(KIND_PEEK_HEAD, $urandom());

    // Shrink the capacity to two while four entries are held. Both remaining slots were
    // written above, so every pop that follows reads a defined word. Pushes are refused
    // while the count is over the capacity, but pops keep draining it.
    quiesce();
    set_capacity(2);
    send_op(KIND_PUSH_TAIL, $urandom());
    send_op(KIND_PEEK_HEAD, $urandom());
    send_op(KIND_POP_HEAD, $urandom());
    send_op(KIND_POP_TAIL, $urandom());
    send_op(KIND_POP_HEAD, $urandom());
    send_op(KIND_POP_TAIL, $urandom());
    send_op(KIND_POP_TAIL, $urandom());
    send_op(3'd7, $urandom());

    // A write to an index with no register is ignored; a capacity of zero acts as one.
    quiesce();
    cfg_write(3'd4, 32'd5);
    cfg_read(3'd0);
    set_capacity(0);
    send_op(KIND_PUSH_HEAD, $urandom());
    send_op(KIND_PUSH_TAIL, $urandom());
    send_op(KIND_PEEK_TAIL, $urandom());
    send_op(KIND_POP_TAIL, $urandom());

    // Random phases, one per capacity setting. The deque is emptied before each change so
    // that no pop can reach a slot that was never written under the new wrap point.
    foreach (phase_caps[p]) begin
      quiesce();
      to_pop = last_count;
      repeat (to_pop) send_op($urandom_range(1) ? KIND_POP_TAIL : KIND_POP_HEAD, $urandom());
      quiesce();
      set_capacity(phase_caps[p]);
      push_pct = 50;
      for (int i = 0; i < 88; i++) begin
        if (i % 24 == 0) begin
          case ($urandom_range(3))
            0:       push_pct = 25;
            1:       push_pct = 50;
            2:       push_pct = 75;
            default: push_pct = 90;
          endcase
        end
        // Now and then the sender holds off until the block has answered everything.
        if ($urandom_range(99) == 0) quiesce();
        send_op(pick_op(push_pct), pick_word());
      end
    end

    quiesce();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && answers_waiting == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
